FILE: design/js7p_pkg.sv
// Shared types and constants for the seven-point 3D Jacobi stencil.
package js7p_pkg;

    localparam int MaxSide  = 64;
    localparam int MinSide  = 3;
    localparam int SideW    = 7;
    localparam int CoefW    = 18;
    localparam int DataW    = 32;
    localparam int AddrW    = 4;
    localparam int PosW     = $clog2(MaxSide);
    localparam int PlaneDepth = MaxSide * (MaxSide - 1);
    localparam int PlaneAw  = $clog2(PlaneDepth);
    localparam int RowDepth = MaxSide - 1;
    localparam int RowAw    = $clog2(RowDepth);
    localparam int RstSide  = 64;

    typedef enum logic [1:0] {
        RegGridSide     = 2'd0,
        RegCenterCoef   = 2'd1,
        RegNeighborCoef = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [DataW-1:0] sample;
        logic                    grid_start;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0] value;
        logic                    last_cell;
    } t_out_item;

endpackage

FILE: design/js7p_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module js7p_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/jacobi_stencil_7pt_3d.sv
// Top level of the seven-point 3D Jacobi stencil engine.
//
// Grid samples enter on the input channel in raster order, x innermost, one
// transfer per sample; grid_start marks the first sample of a grid. After the
// last sample of a grid the position wraps, so grids may follow back to back.
// Each interior cell gives one result transfer on the output channel once the
// sample one plane ahead of it has arrived; boundary cells give none.
// The block takes one sample per clock cycle unless the result stages are
// full. A result reaches the output register through a pairwise adder stage,
// a summing adder stage, a multiplier stage and a rounding stage. The window
// is built from four delay lines, each a RAM with one read and one write per
// cycle, two of them a plane minus a row long and two a row minus one long.
// When the receiver stalls, the result stages fill up; input transfers go on
// until all four hold a result, then the input stalls too. Reset returns the
// position to the grid origin, the side to 64 and both coefficients to zero;
// the window RAM contents are not cleared and need no clearing pass, since a
// cell only reads samples of its own grid. Writing the side register restarts
// the grid; the user must write it only while idle; the block does not check.
module jacobi_stencil_7pt_3d (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  js7p_pkg::t_in_item       i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output js7p_pkg::t_out_item      o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [js7p_pkg::AddrW-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    import js7p_pkg::*;

    logic [SideW-1:0]        r_side;
    logic signed [CoefW-1:0] r_center_coef;
    logic signed [CoefW-1:0] r_neighbor_coef;
    logic [PlaneAw-1:0]      r_plane_last;
    logic [RowAw-1:0]        r_row_last;
    logic [PosW-1:0]         r_nm1;
    logic [PosW-1:0]         r_nm2;

    logic [PosW-1:0]         r_x;
    logic [PosW-1:0]         r_y;
    logic [PosW-1:0]         r_z;
    logic [PlaneAw-1:0]      r_ptr_p;
    logic [RowAw-1:0]        r_ptr_r;

    logic                    cfg_wr;
    t_reg_idx                cfg_idx;
    logic                    side_wr;
    logic [SideW-1:0]        side_src;
    logic [SideW-1:0]        side_eff;
    logic [2*SideW-1:0]      plane_len;

    logic                    in_acc;
    logic                    restart;
    logic [PosW-1:0]         cur_x;
    logic [PosW-1:0]         cur_y;
    logic [PosW-1:0]         cur_z;
    logic                    x_wrap;
    logic                    y_wrap;
    logic                    z_wrap;
    logic                    interior;
    logic                    last;
    logic [PosW-1:0]         n_x;
    logic [PosW-1:0]         n_y;
    logic [PosW-1:0]         n_z;
    logic [PlaneAw-1:0]      wp_p;
    logic [PlaneAw-1:0]      n_ptr_p;
    logic [RowAw-1:0]        wp_r;
    logic [RowAw-1:0]        n_ptr_r;

    logic [DataW-1:0]        tap_a;
    logic [DataW-1:0]        tap_b;
    logic [DataW-1:0]        tap_c;
    logic [DataW-1:0]        tap_d;
    logic [DataW-1:0]        r_tap_ctr;
    logic [DataW-1:0]        r_tap_xm;

    logic                    c1;
    logic                    c2;
    logic                    c3;
    logic                    c_o;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic                    r_vo;

    logic signed [32:0]      r1_p0;
    logic signed [32:0]      r1_p1;
    logic signed [32:0]      r1_p2;
    logic signed [31:0]      r1_ctr;
    logic                    r1_last;
    logic signed [34:0]      r2_sum;
    logic signed [31:0]      r2_ctr;
    logic                    r2_last;
    logic signed [49:0]      r3_pc;
    logic signed [52:0]      r3_pn;
    logic                    r3_last;
    logic signed [53:0]      acc;
    logic signed [37:0]      quo;
    logic signed [31:0]      sat;
    t_out_item               r_out;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign side_wr = cfg_wr && (cfg_idx == RegGridSide);

    assign side_src = !i_rst_n ? SideW'(RstSide) : pwdata[SideW-1:0];

    always_comb begin
        if (side_src < SideW'(MinSide)) begin
            side_eff = SideW'(MinSide);
        end else if (side_src > SideW'(MaxSide)) begin
            side_eff = SideW'(MaxSide);
        end else begin
            side_eff = side_src;
        end
        plane_len = (2*SideW)'(side_eff) * (2*SideW)'(side_eff - SideW'(1));
    end

    always_comb begin
        unique case (cfg_idx)
            RegGridSide:     prdata = {{(32-SideW){1'b0}}, r_side};
            RegCenterCoef:   prdata = {{(32-CoefW){r_center_coef[CoefW-1]}}, r_center_coef};
            RegNeighborCoef: prdata = {{(32-CoefW){r_neighbor_coef[CoefW-1]}},
                                       r_neighbor_coef};
            default:         prdata = '0;
        endcase
    end

    // Raster position and delay line pointers.
    assign in_acc  = i_in_valid && o_in_ready;
    assign restart = i_in.grid_start;

    always_comb begin
        cur_x    = restart ? '0 : r_x;
        cur_y    = restart ? '0 : r_y;
        cur_z    = restart ? '0 : r_z;
        interior = (cur_z >= PosW'(2)) && (cur_y != '0) && (cur_y <= r_nm2)
                   && (cur_x != '0) && (cur_x <= r_nm2);
        last     = (cur_x == r_nm2) && (cur_y == r_nm2) && (cur_z == r_nm1);
        x_wrap   = (cur_x == r_nm1);
        y_wrap   = (cur_y == r_nm1);
        z_wrap   = (cur_z == r_nm1);
        n_x      = x_wrap ? '0 : cur_x + PosW'(1);
        n_y      = cur_y;
        n_z      = cur_z;
        if (x_wrap) begin
            n_y = y_wrap ? '0 : cur_y + PosW'(1);
            if (y_wrap) begin
                n_z = z_wrap ? '0 : cur_z + PosW'(1);
            end
        end
    end

    always_comb begin
        wp_p = restart ? '0 : r_ptr_p;
        wp_r = restart ? '0 : r_ptr_r;
        if (side_wr) begin
            n_ptr_p = '0;
            n_ptr_r = '0;
        end else if (in_acc) begin
            n_ptr_p = (wp_p == r_plane_last) ? '0 : wp_p + PlaneAw'(1);
            n_ptr_r = (wp_r == r_row_last) ? '0 : wp_r + RowAw'(1);
        end else begin
            n_ptr_p = r_ptr_p;
            n_ptr_r = r_ptr_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || side_wr) begin
            r_side       <= side_src;
            r_plane_last <= PlaneAw'(plane_len - (2*SideW)'(1));
            r_row_last   <= RowAw'(side_eff - SideW'(2));
            r_nm1        <= PosW'(side_eff - SideW'(1));
            r_nm2        <= PosW'(side_eff - SideW'(2));
            r_x          <= '0;
            r_y          <= '0;
            r_z          <= '0;
            r_ptr_p      <= '0;
            r_ptr_r      <= '0;
        end else if (in_acc) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_ptr_p <= n_ptr_p;
            r_ptr_r <= n_ptr_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_coef   <= '0;
            r_neighbor_coef <= '0;
        end else if (cfg_wr && (cfg_idx == RegCenterCoef)) begin
            r_center_coef <= pwdata[CoefW-1:0];
        end else if (cfg_wr && (cfg_idx == RegNeighborCoef)) begin
            r_neighbor_coef <= pwdata[CoefW-1:0];
        end
    end

    // Window delay lines: a plane minus a row, a row minus one, two single
    // taps, a row minus one, and a plane minus a row.
    js7p_ram #(.DEPTH(PlaneDepth), .WIDTH(DataW)) u_plane_a (
        .i_clk     (i_clk),
        .i_we      (in_acc),
        .i_wr_addr (wp_p),
        .i_wr_data (i_in.sample),
        .i_rd_addr (n_ptr_p),
        .o_rd_data (tap_a)
    );

    js7p_ram #(.DEPTH(RowDepth), .WIDTH(DataW)) u_row_b (
        .i_clk     (i_clk),
        .i_we      (in_acc),
        .i_wr_addr (wp_r),
        .i_wr_data (tap_a),
        .i_rd_addr (n_ptr_r),
        .o_rd_data (tap_b)
    );

    js7p_ram #(.DEPTH(RowDepth), .WIDTH(DataW)) u_row_c (
        .i_clk     (i_clk),
        .i_we      (in_acc),
        .i_wr_addr (wp_r),
        .i_wr_data (r_tap_xm),
        .i_rd_addr (n_ptr_r),
        .o_rd_data (tap_c)
    );

    js7p_ram #(.DEPTH(PlaneDepth), .WIDTH(DataW)) u_plane_d (
        .i_clk     (i_clk),
        .i_we      (in_acc),
        .i_wr_addr (wp_p),
        .i_wr_data (tap_c),
        .i_rd_addr (n_ptr_p),
        .o_rd_data (tap_d)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tap_ctr <= tap_b;
            r_tap_xm  <= r_tap_ctr;
        end
    end

    // Result pipeline with per-stage flow control.
    assign c_o        = !r_vo || i_out_ready;
    assign c3         = !r_v3 || c_o;
    assign c2         = !r_v2 || c3;
    assign c1         = !r_v1 || c2;
    assign o_in_ready = c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (c1) begin
                r_v1 <= in_acc && interior;
            end
            if (c2) begin
                r_v2 <= r_v1;
            end
            if (c3) begin
                r_v3 <= r_v2;
            end
            if (c_o) begin
                r_vo <= r_v3;
            end
        end
    end

    always_comb begin
        acc = {{4{r3_pc[49]}}, r3_pc} + {r3_pn[52], r3_pn} + 54'sd32768;
        quo = acc[53:16];
        if ((&quo[37:31]) || !(|quo[37:31])) begin
            sat = quo[31:0];
        end else if (quo[37]) begin
            sat = {1'b1, {31{1'b0}}};
        end else begin
            sat = {1'b0, {31{1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (c1) begin
            r1_p0   <= $signed({i_in.sample[31], i_in.sample}) + $signed({tap_a[31], tap_a});
            r1_p1   <= $signed({tap_b[31], tap_b}) + $signed({r_tap_xm[31], r_tap_xm});
            r1_p2   <= $signed({tap_c[31], tap_c}) + $signed({tap_d[31], tap_d});
            r1_ctr  <= $signed(r_tap_ctr);
            r1_last <= last;
        end
        if (c2) begin
            r2_sum  <= {{2{r1_p0[32]}}, r1_p0} + {{2{r1_p1[32]}}, r1_p1}
                       + {{2{r1_p2[32]}}, r1_p2};
            r2_ctr  <= r1_ctr;
            r2_last <= r1_last;
        end
        if (c3) begin
            r3_pc   <= r_center_coef * r2_ctr;
            r3_pn   <= r_neighbor_coef * r2_sum;
            r3_last <= r2_last;
        end
        if (c_o) begin
            r_out.value     <= sat;
            r_out.last_cell <= r3_last;
        end
    end

    assign o_out_valid = r_vo;
    assign o_out       = r_out;

    a_plane_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr_p <= r_plane_last)
        else $error("Plane pointer beyond the delay length.");

    a_row_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr_r <= r_row_last)
        else $error("Row pointer beyond the delay length.");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x <= r_nm1) && (r_y <= r_nm1) && (r_z <= r_nm1))
        else $error("Grid position outside the grid.");

    a_interior_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && interior) |=> r_v1)
        else $error("Interior cell transfer did not enter the result pipeline.");

endmodule
